// ===== rtl/double_ended_queue_defines.svh =====
// Assertion macros for the double-ended queue.
// Both assume a clock named clk and an active-low reset named arst_n.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dq assertion failed");
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dq assertion failed");
`else
`define DQ_ASSERT(lbl, prop)
`define DQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dq_pkg.sv =====
package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_LIST       = 3'd4
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_e_t;

	typedef struct packed {
		logic [2:0] op;
		word_t      value;
	} cmd_t;

	typedef struct packed {
		word_t      item_value;
		logic [1:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} ram_req_t;

	// (base + off) mod DEPTH; the sum stays below 2*DEPTH
	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return idx_t'(sum);
	endfunction

endpackage

// ===== rtl/dq_ram.sv =====
module dq_ram #(
	parameter int DATA_W = 32,
	parameter int WORDS  = 16,
	parameter int ADDR_W = $clog2(WORDS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dq_ctrl.sv =====
`include "double_ended_queue_defines.svh"

module dq_ctrl import dq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  cmd_t     cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output res_t     res,
	output ram_req_t ram_req,
	input  word_t    ram_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_LIST_RD,
		S_LIST_DATA
	} state_t;

	state_t state_q;
	idx_t   head_q;
	cnt_t   cnt_q;
	cnt_t   idx_q;
	logic   res_valid_q;
	res_t   res_q;

	logic res_free;
	logic cmd_take;
	logic full;
	logic empty;
	logic last_idx;
	logic res_load;

	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_take  = cmd_valid && (state_q == S_IDLE) && res_free;
	assign cmd_stall = !((state_q == S_IDLE) && res_free);
	assign full      = (cnt_q == cnt_t'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign last_idx  = (cnt_t'(idx_q + 1'b1) == cnt_q);

	// a new transaction enters the output register this cycle
	always_comb begin
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_REAR: res_load = 1'b1;
						OP_POP_FRONT, OP_POP_REAR, OP_LIST: res_load = empty;
						default: res_load = 1'b0;
					endcase
				end
			end
			S_POP:       res_load = 1'b1;
			S_LIST_DATA: res_load = res_free;
			default:     res_load = 1'b0;
		endcase
	end

	always_comb begin
		ram_req       = '0;
		ram_req.waddr = head_q;
		ram_req.wdata = cmd.value;
		ram_req.raddr = head_q;
		if (cmd_take) begin
			case (cmd.op)
				OP_PUSH_FRONT: begin
					ram_req.we    = !full;
					ram_req.waddr = ring_add(head_q, cnt_t'(DEPTH - 1));
				end
				OP_PUSH_REAR: begin
					ram_req.we    = !full;
					ram_req.waddr = ring_add(head_q, cnt_q);
				end
				OP_POP_FRONT: begin
					ram_req.re = !empty;
				end
				OP_POP_REAR: begin
					ram_req.re    = !empty;
					ram_req.raddr = ring_add(head_q, cnt_q - 1'b1);
				end
				default: ;
			endcase
		end else if (state_q == S_LIST_RD) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = ring_add(head_q, idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						res_q.item_value <= '0;
						res_q.last       <= 1'b1;
						case (cmd.op)
							OP_PUSH_FRONT, OP_PUSH_REAR: begin
								if (full) begin
									res_q.status <= ST_FULL;
								end else begin
									res_q.status <= ST_OK;
									cnt_q        <= cnt_q + 1'b1;
									if (cmd.op == OP_PUSH_FRONT) begin
										head_q <= ring_add(head_q, cnt_t'(DEPTH - 1));
									end
								end
							end
							OP_POP_FRONT, OP_POP_REAR: begin
								if (empty) begin
									res_q.status <= ST_EMPTY;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= S_POP;
									if (cmd.op == OP_POP_FRONT) begin
										head_q <= ring_add(head_q, cnt_t'(1));
									end
								end
							end
							OP_LIST: begin
								if (empty) begin
									res_q.status <= ST_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_LIST_RD;
								end
							end
							default: ;  // unused codes give no transaction
						endcase
					end
				end
				S_POP: begin
					// output register was free when the pop was taken
					res_q.item_value <= ram_rdata;
					res_q.status     <= ST_OK;
					res_q.last       <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_LIST_RD: begin
					state_q <= S_LIST_DATA;
				end
				S_LIST_DATA: begin
					// read data holds until the next read is issued
					if (res_free) begin
						res_q.item_value <= ram_rdata;
						res_q.status     <= ST_OK;
						res_q.last       <= last_idx;
						if (last_idx) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_LIST_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`DQ_ASSERT(a_cnt_bound, cnt_q <= cnt_t'(DEPTH))
	`DQ_ASSERT(a_no_take_when_blocked, (res_valid_q && res_stall) |-> !cmd_take)
	`DQ_ASSERT_NEXT(a_pop_delivers, state_q == S_POP, res_valid_q && res_q.last)
	`DQ_ASSERT_NEXT(a_push_counts,
		cmd_take && !full && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_REAR),
		cnt_q == $past(cnt_q) + 1'b1)
	`DQ_ASSERT(a_list_idx_bound, (state_q == S_LIST_RD || state_q == S_LIST_DATA) |-> idx_q < cnt_q)

endmodule

// ===== rtl/double_ended_queue.sv =====
// Results: push and failed operations load the result register at acceptance; a pop
// first reads the entry RAM into its read register and loads the result in S_POP.
// Throughput: one operation at a time; a pop passes through S_POP, and a list reads
// entries one at a time via S_LIST_RD and S_LIST_DATA on the RAM's single read port.
// Reset (arst_n low) empties the queue: head index and count go to zero; the RAM
// keeps its contents and needs no clearing pass, the block is ready at once.
module double_ended_queue import dq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	ram_req_t ram_req;
	word_t    ram_rdata;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	dq_ram #(
		.DATA_W (WORD_W),
		.WORDS  (DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
